FILE: rtl/tfr_pkg.sv
// tfr_pkg: shared types and constants for the time frame receiver
// no dependencies

package tfr_pkg;

  localparam int FRAME_LEN = 5;
  localparam int FILL_W = 3;
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_LEN - 1);
  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [7:0] MAX_HOUR = 8'd23;
  localparam logic [7:0] MAX_MIN = 8'd59;
  localparam logic [7:0] MAX_SEC = 8'd59;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_TAKE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       rx_byte;
    logic       line_err;
    logic       take;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       took;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       pending;
    logic       accepted;
    logic       rejected;
  } frame_stat_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] errors;
    logic [31:0] bad;
    logic [7:0]  last;
  } count_stat_t;

endpackage

FILE: rtl/tfr_frame.sv
// tfr_frame: frame assembly, running check, time hold and pending flag
// depends on tfr_pkg

module tfr_frame import tfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  cmd_t        cmd,
  input  logic [7:0]  header,
  output frame_stat_t stat
);

  logic [FILL_W-1:0] fill, fill_next;
  logic [1:0]        fill_m1;
  logic [7:0]        xor_acc, xor_next;
  logic [7:0]        fb [FRAME_LEN-2];
  logic              pending, pending_next;
  logic [4:0]        hold_h, hold_h_next;
  logic [5:0]        hold_m, hold_m_next;
  logic [5:0]        hold_s, hold_s_next;
  logic              wr_en, took, acc, rej;

  assign fill_m1 = fill[1:0] - 2'd1;

  always_comb begin
    fill_next    = fill;
    xor_next     = xor_acc;
    pending_next = pending;
    hold_h_next  = hold_h;
    hold_m_next  = hold_m;
    hold_s_next  = hold_s;
    wr_en        = 1'b0;
    took         = 1'b0;
    acc          = 1'b0;
    rej          = 1'b0;
    if (cmd.line_err) begin
      fill_next = '0;
    end else if (cmd.take) begin
      if (pending) begin
        took         = 1'b1;
        pending_next = 1'b0;
      end
    end else if (cmd.rx_byte) begin
      if (fill == '0) begin
        if (cmd.data == header) begin
          fill_next = FILL_W'(1);
          xor_next  = cmd.data;
        end
      end else if (fill < LAST_FILL) begin
        wr_en     = 1'b1;
        fill_next = fill + FILL_W'(1);
        xor_next  = xor_acc ^ cmd.data;
      end else begin
        fill_next = '0;
        if (xor_acc == cmd.data && fb[0] <= MAX_HOUR &&
            fb[1] <= MAX_MIN && fb[2] <= MAX_SEC) begin
          hold_h_next  = fb[0][4:0];
          hold_m_next  = fb[1][5:0];
          hold_s_next  = fb[2][5:0];
          pending_next = 1'b1;
          acc          = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      pending <= 1'b0;
      hold_h  <= '0;
      hold_m  <= '0;
      hold_s  <= '0;
    end else if (fire) begin
      fill    <= fill_next;
      pending <= pending_next;
      hold_h  <= hold_h_next;
      hold_m  <= hold_m_next;
      hold_s  <= hold_s_next;
    end
  end

  // frame payload, only read once written in the same frame
  always_ff @(posedge clk) begin
    if (fire) begin
      xor_acc <= xor_next;
    end
    if (fire && wr_en) begin
      fb[fill_m1] <= cmd.data;
    end
  end

  always_comb begin
    stat.took     = took;
    stat.hour     = hold_h_next;
    stat.minute   = hold_m_next;
    stat.second   = hold_s_next;
    stat.pending  = pending_next;
    stat.accepted = acc;
    stat.rejected = rej;
  end

endmodule

FILE: rtl/tfr_stats.sv
// tfr_stats: byte, line error and bad frame counters plus last byte
// depends on tfr_pkg

module tfr_stats import tfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  cmd_t        cmd,
  input  logic        rejected,
  output count_stat_t stat
);

  logic [31:0] total, total_next;
  logic [31:0] errors, errors_next;
  logic [31:0] bad, bad_next;
  logic [7:0]  last, last_next;

  always_comb begin
    total_next  = cmd.rx_byte  ? total + 32'd1  : total;
    errors_next = cmd.line_err ? errors + 32'd1 : errors;
    bad_next    = rejected     ? bad + 32'd1    : bad;
    last_next   = cmd.rx_byte  ? cmd.data       : last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      errors <= '0;
      bad    <= '0;
      last   <= '0;
    end else if (fire) begin
      total  <= total_next;
      errors <= errors_next;
      bad    <= bad_next;
      last   <= last_next;
    end
  end

  always_comb begin
    stat.total  = total_next;
    stat.errors = errors_next;
    stat.bad    = bad_next;
    stat.last   = last_next;
  end

endmodule

FILE: rtl/time_frame_receiver.sv
// time_frame_receiver: top level with input register, decode and result register
// depends on tfr_pkg, tfr_frame, tfr_stats

// Takes one transaction per cycle while in_stall is low: a received byte, a
// line error event or a take request. Each transaction passes through the
// input register, where the frame state and counters update, and then waits
// in the result register until taken; throughput is one per cycle while
// out_stall is low. in_stall rises only when both registers
// hold work and the result side stalls. frame_header is written through
// cfg_write/cfg_data and should only change while no transaction is in
// flight.
module time_frame_receiver import tfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        took_time,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        time_pending,
  output logic        frame_accepted,
  output logic        frame_rejected,
  output logic [31:0] total_bytes,
  output logic [31:0] error_events,
  output logic [31:0] bad_frames,
  output logic [7:0]  last_byte
);

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [7:0]  s1_data;
  logic        out_load, fire;
  logic [7:0]  header;
  cmd_t        cmd;
  frame_stat_t fstat;
  count_stat_t cstat;

  assign out_load = !out_valid || !out_stall;
  assign fire     = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= HEADER_RESET;
    end else if (cfg_write) begin
      header <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_data <= byte_value;
    end
  end

  always_comb begin
    cmd.rx_byte  = 1'b0;
    cmd.line_err = 1'b0;
    cmd.take     = 1'b0;
    cmd.data     = s1_data;
    case (kind_t'(s1_kind))
      KIND_BYTE:  cmd.rx_byte  = 1'b1;
      KIND_ERROR: cmd.line_err = 1'b1;
      KIND_TAKE:  cmd.take     = 1'b1;
      default:    cmd.rx_byte  = 1'b0;
    endcase
  end

  tfr_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cmd    (cmd),
    .header (header),
    .stat   (fstat)
  );

  tfr_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd      (cmd),
    .rejected (fstat.rejected),
    .stat     (cstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      took_time      <= fstat.took;
      hour           <= fstat.hour;
      minute         <= fstat.minute;
      second         <= fstat.second;
      time_pending   <= fstat.pending;
      frame_accepted <= fstat.accepted;
      frame_rejected <= fstat.rejected;
      total_bytes    <= cstat.total;
      error_events   <= cstat.errors;
      bad_frames     <= cstat.bad;
      last_byte      <= cstat.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_accepted && frame_rejected))
    else $error("frame both accepted and rejected");

  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_accepted) |-> time_pending)
    else $error("accepted frame without pending time");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && took_time) |-> !time_pending)
    else $error("pending flag still set after take");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid))
    else $error("input stalled without a blocked result");
`endif

endmodule

FILE: sim/time_frame_checker.sv
// time_frame_checker: predicts and compares time frame receiver results
// watches both channels and the header write port; depends on tfr_pkg

module time_frame_checker import tfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        took_time,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  input  logic        time_pending,
  input  logic        frame_accepted,
  input  logic        frame_rejected,
  input  logic [31:0] total_bytes,
  input  logic [31:0] error_events,
  input  logic [31:0] bad_frames,
  input  logic [7:0]  last_byte,
  output int          mismatches,
  output int          awaiting
);

  localparam logic [7:0] HOUR_LIMIT = 8'd23;
  localparam logic [7:0] MINUTE_LIMIT = 8'd59;
  localparam logic [7:0] SECOND_LIMIT = 8'd59;
  localparam logic [7:0] HEADER_AT_RESET = 8'h55;
  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    frame_stat_t frame;
    count_stat_t count;
  } time_result_t;

  time_result_t expected_times[$];
  logic [7:0]  header_q;
  logic [2:0]  fill;
  logic [7:0]  frame_buf [4];
  logic        pending;
  logic [7:0]  held [3];
  logic [31:0] byte_count;
  logic [31:0] error_count;
  logic [31:0] bad_count;
  logic [7:0]  recent;
  int          fail_count = 0;
  int          depth = 0;

  assign mismatches = fail_count;
  assign awaiting = depth;

  function automatic time_result_t predict_time(input logic [1:0] k, input logic [7:0] b);
    time_result_t r;
    logic [7:0] x;
    r = '0;
    if (k == KIND_BYTE) begin
      byte_count = byte_count + 32'd1;
      recent = b;
      if (fill == 3'd0) begin
        if (b == header_q) begin
          frame_buf[0] = b;
          fill = 3'd1;
        end
      end else if (fill < 3'd4) begin
        frame_buf[fill[1:0]] = b;
        fill = fill + 3'd1;
      end else begin
        // check byte closes the frame
        x = frame_buf[0] ^ frame_buf[1] ^ frame_buf[2] ^ frame_buf[3];
        if (x == b && frame_buf[1] <= HOUR_LIMIT && frame_buf[2] <= MINUTE_LIMIT &&
            frame_buf[3] <= SECOND_LIMIT) begin
          held[0] = frame_buf[1];
          held[1] = frame_buf[2];
          held[2] = frame_buf[3];
          pending = 1'b1;
          r.frame.accepted = 1'b1;
        end else begin
          bad_count = bad_count + 32'd1;
          r.frame.rejected = 1'b1;
        end
        fill = 3'd0;
      end
    end else if (k == KIND_ERROR) begin
      error_count = error_count + 32'd1;
      fill = 3'd0;
    end else if (k == KIND_TAKE) begin
      if (pending) begin
        r.frame.took = 1'b1;
        pending = 1'b0;
      end
    end
    r.frame.hour = held[0][4:0];
    r.frame.minute = held[1][5:0];
    r.frame.second = held[2][5:0];
    r.frame.pending = pending;
    r.count.total = byte_count;
    r.count.errors = error_count;
    r.count.bad = bad_count;
    r.count.last = recent;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log short when the design is badly off
    if (fail_count < PRINT_LIMIT)
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    time_result_t e;
    if (rst) begin
      header_q = HEADER_AT_RESET;
      fill = 3'd0;
      pending = 1'b0;
      held[0] = 8'd0;
      held[1] = 8'd0;
      held[2] = 8'd0;
      byte_count = 32'd0;
      error_count = 32'd0;
      bad_count = 32'd0;
      recent = 8'd0;
      expected_times.delete();
    end else begin
      if (cfg_write)
        header_q = cfg_data;
      if (in_valid && !in_stall)
        expected_times.push_back(predict_time(kind, byte_value));
      if (out_valid && !out_stall) begin
        if (expected_times.size() == 0) begin
          report_mismatch("transaction with none expected", 32'd0, 32'd0);
        end else begin
          e = expected_times.pop_front();
          if (took_time !== e.frame.took)
            report_mismatch("took_time", 32'(took_time), 32'(e.frame.took));
          if (hour !== e.frame.hour)
            report_mismatch("hour", 32'(hour), 32'(e.frame.hour));
          if (minute !== e.frame.minute)
            report_mismatch("minute", 32'(minute), 32'(e.frame.minute));
          if (second !== e.frame.second)
            report_mismatch("second", 32'(second), 32'(e.frame.second));
          if (time_pending !== e.frame.pending)
            report_mismatch("time_pending", 32'(time_pending), 32'(e.frame.pending));
          if (frame_accepted !== e.frame.accepted)
            report_mismatch("frame_accepted", 32'(frame_accepted), 32'(e.frame.accepted));
          if (frame_rejected !== e.frame.rejected)
            report_mismatch("frame_rejected", 32'(frame_rejected), 32'(e.frame.rejected));
          if (total_bytes !== e.count.total)
            report_mismatch("total_bytes", total_bytes, e.count.total);
          if (error_events !== e.count.errors)
            report_mismatch("error_events", error_events, e.count.errors);
          if (bad_frames !== e.count.bad)
            report_mismatch("bad_frames", bad_frames, e.count.bad);
          if (last_byte !== e.count.last)
            report_mismatch("last_byte", 32'(last_byte), 32'(e.count.last));
        end
      end
    end
    depth = expected_times.size();
  end

endmodule

FILE: sim/time_frame_receiver_test.sv
// time_frame_receiver_test: stimulus, idling and verdict for the time frame receiver
// depends on tfr_pkg, time_frame_receiver and time_frame_checker

module time_frame_receiver_test;
  import tfr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 620;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_BYTE;
  logic [7:0]  byte_value = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        took_time;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        time_pending;
  logic        frame_accepted;
  logic        frame_rejected;
  logic [31:0] total_bytes;
  logic [31:0] error_events;
  logic [31:0] bad_frames;
  logic [7:0]  last_byte;
  int          mismatches;
  int          awaiting;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [7:0]  cur_header = HEADER_RESET;

  time_frame_receiver u_top (.*);
  time_frame_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    byte_value <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait until every transaction in flight has come out
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_header = v;
  endtask

  task automatic send_time_frame(input logic [7:0] h, input logic [7:0] m,
                                 input logic [7:0] s, input logic [7:0] flip);
    send_item(KIND_BYTE, cur_header);
    send_item(KIND_BYTE, h);
    send_item(KIND_BYTE, m);
    send_item(KIND_BYTE, s);
    send_item(KIND_BYTE, cur_header ^ h ^ m ^ s ^ flip);
  endtask

  function automatic logic [7:0] pick_time_field(input logic [7:0] top_ok);
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(top_ok));
    if (r < 80) return top_ok;
    if (r < 90) return top_ok + 8'd1;
    return 8'($urandom_range(255, top_ok + 1));
  endfunction

  task automatic random_chunk();
    int r;
    int n;
    logic [7:0] flip;
    r = $urandom_range(99);
    if (r < 55) begin
      flip = ($urandom_range(99) < 12) ? 8'(1 << $urandom_range(7)) : 8'd0;
      send_time_frame(pick_time_field(8'd23), pick_time_field(8'd59),
                      pick_time_field(8'd59), flip);
    end else if (r < 65) begin
      send_item(KIND_BYTE, 8'($urandom_range(255)));
    end else if (r < 77) begin
      send_item(KIND_TAKE, 8'($urandom_range(255)));
    end else if (r < 83) begin
      send_item(KIND_ERROR, 8'($urandom_range(255)));
    end else if (r < 86) begin
      send_item(KIND_UNUSED, 8'($urandom_range(255)));
    end else begin
      // partial frame cut by a line error or by stray bytes
      n = $urandom_range(3);
      send_item(KIND_BYTE, cur_header);
      repeat (n) send_item(KIND_BYTE, 8'($urandom_range(255)));
      if ($urandom_range(1)) send_item(KIND_ERROR, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 2) settle_block();
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) random_chunk();
    settle_block();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 74;

    send_item(KIND_TAKE, 8'h00);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_ERROR, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_time_frame(8'd0, 8'd0, 8'd0, 8'd0);
    send_item(KIND_TAKE, 8'h00);
    send_item(KIND_TAKE, 8'h00);
    send_time_frame(8'd23, 8'd59, 8'd59, 8'd0);
    send_time_frame(8'd24, 8'd0, 8'd0, 8'd0);
    send_item(KIND_BYTE, cur_header);
    send_item(KIND_BYTE, 8'd1);
    send_item(KIND_ERROR, 8'hFF);
    settle_block();

    write_header(8'h00);
    run_phase(19, 74);
    write_header(8'hFF);
    run_phase(74, 19);
    write_header(8'($urandom_range(255)));
    run_phase(0, 0);

    if (mismatches == 0 && awaiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: time_frame_receiver.f
rtl/tfr_pkg.sv
rtl/tfr_frame.sv
rtl/tfr_stats.sv
rtl/time_frame_receiver.sv
sim/time_frame_checker.sv
sim/time_frame_receiver_test.sv
